// ----- rtl/apjb_pkg.sv -----
// ----------------------------------------------------------------------------
// Adaptive playout jitter buffer package
// Item kinds, playout modes, register indexes and reset values used by the
// top-level module.
// ----------------------------------------------------------------------------
`default_nettype none

package apjb_pkg;

    // Item kinds on the input channel.
    localparam logic KIND_PUSH    = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // Playout modes of a result item.
    localparam logic [1:0] MODE_EMPTY       = 2'd0;
    localparam logic [1:0] MODE_HOLD_OLDEST = 2'd1;
    localparam logic [1:0] MODE_HOLD_NEWEST = 2'd2;
    localparam logic [1:0] MODE_INTERP      = 2'd3;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SNAP_DISTANCE = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_DELAY     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_DELAY     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INITIAL_DELAY = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STALL_LIMIT   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHRINK_WINDOW = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CATCHUP_GAIN  = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_WARP      = 3'd7;

    // Register reset values.
    localparam logic [15:0] RST_SNAP_DISTANCE = 16'd7680;
    localparam logic [13:0] RST_MIN_DELAY     = 14'd512;
    localparam logic [13:0] RST_MAX_DELAY     = 14'd3072;
    localparam logic [13:0] RST_INITIAL_DELAY = 14'd768;
    localparam logic [9:0]  RST_STALL_LIMIT   = 10'd6;
    localparam logic [15:0] RST_SHRINK_WINDOW = 16'd60;
    localparam logic [7:0]  RST_CATCHUP_GAIN  = 8'd26;
    localparam logic [7:0]  RST_MAX_WARP      = 8'd26;

    // Blend fraction is always Q.8.
    localparam int BLEND_BITS = 8;

    // Saturation value of the run counters.
    localparam logic [15:0] RUN_MAX = 16'hFFFF;

endpackage

`default_nettype wire

// ----- rtl/adaptive_playout_jitter_buffer_top.sv -----
// ----------------------------------------------------------------------------
// Adaptive playout jitter buffer
// Tick-sorted sample store with an adaptive Q.FRAC_BITS playback cursor.
// ----------------------------------------------------------------------------
// Usage. The input channel (i_in_valid / o_in_ready) carries one item per
// handshake: a push item (i_kind = 0) stores a sample under its sender tick,
// an advance item (i_kind = 1) steps or snaps the playback cursor and yields
// exactly one result item on the output channel (o_out_valid / i_out_ready).
// Push items yield no result item.
// All samples live in one RAM of DEPTH entries, {tick, payload} wide, used as
// a ring sorted by tick. Each access is a registered read, so the sequencer
// sets the rate: a push keeps the input busy while it scans for its place and
// shifts the entries above it up; an interpolating advance also searches for
// the bracketing entries, runs an 8-step division for the blend fraction and
// drops the entries that playback has passed. An advance on an empty buffer
// goes straight to the output register.
// Results sit in an output register: the block goes on taking push items
// while a result waits, and only an advance that finishes while the previous
// result is still unaccepted waits for the receiver.
// Reset (synchronous, active low) empties the buffer, clears the cursor and
// the counters and loads every register with its default. No RAM clearing
// pass is needed, since only entries inside the fill count are ever read.
// Configuration writes are taken in the cycle they are presented and must
// only be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_playout_jitter_buffer_top #(
    parameter int DEPTH        = 32,
    parameter int PAYLOAD_BITS = 64,
    parameter int FRAC_BITS    = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port.
    input  wire logic                                i_cfg_we,
    input  wire logic [apjb_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [apjb_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // Input channel.
    input  wire logic                                i_in_valid,
    output      logic                                o_in_ready,
    input  wire logic                                i_kind,
    input  wire logic [31:0]                         i_sample_tick,
    input  wire logic [PAYLOAD_BITS-1:0]             i_sample_payload,
    // Output channel.
    output      logic                                o_out_valid,
    input  wire logic                                i_out_ready,
    output      logic [1:0]                          o_playout_mode,
    output      logic [PAYLOAD_BITS-1:0]             o_first_payload,
    output      logic [PAYLOAD_BITS-1:0]             o_second_payload,
    output      logic [apjb_pkg::BLEND_BITS-1:0]     o_blend_fraction,
    output      logic [31:0]                         o_starvation_total,
    output      logic [31:0]                         o_snap_total
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int TQW  = 32 + FRAC_BITS;
    localparam int CURW = TQW + 2;
    localparam int DLW  = ((FRAC_BITS > 14) ? FRAC_BITS : 14) + 3;
    localparam int RW   = 32 + PAYLOAD_BITS;
    localparam int BB   = apjb_pkg::BLEND_BITS;
    localparam logic [CURW-1:0] ONE_C   = CURW'(1) << FRAC_BITS;
    localparam logic [DLW-1:0]  ONE_D   = DLW'(1) << FRAC_BITS;
    localparam logic [DLW-1:0]  HALF_D  = DLW'(1) << (FRAC_BITS - 1);
    localparam logic [CNTW-1:0] DEPTH_C = CNTW'(DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_PLACE, S_SHIFT_RD, S_SHIFT_WR, S_INSERT,
        S_NEW_RD, S_OLD_RD, S_ERR, S_CUR, S_CLASS, S_UP_RD, S_UP_CMP, S_DIV,
        S_DROP_RD, S_DROP_CMP, S_STAT, S_DONE
    } t_state;

    // Ring position of the entry that is ofs places above the oldest one.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CNTW-1:0] ofs);
        logic [CNTW:0] s;
        s = (CNTW+1)'(base) + (CNTW+1)'(ofs);
        if (s >= (CNTW+1)'(DEPTH)) begin
            s = s - (CNTW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // A tick as a signed cursor value.
    function automatic logic signed [CURW-1:0] q_of(input logic [31:0] tick);
        return $signed({2'b00, tick, {FRAC_BITS{1'b0}}});
    endfunction

    t_state r_state;

    // Configuration.
    logic [15:0] r_snap_distance;
    logic [13:0] r_min_delay;
    logic [13:0] r_max_delay;
    logic [9:0]  r_stall_limit;
    logic [15:0] r_shrink_window;
    logic [7:0]  r_catchup_gain;
    logic [7:0]  r_max_warp;

    // Buffer and playback state.
    logic [CNTW-1:0]        r_fill;
    logic [AW-1:0]          r_oldest;
    logic signed [CURW-1:0] r_cursor;
    logic                   r_started;
    logic [13:0]            r_delay;
    logic [15:0]            r_clean_run;
    logic [15:0]            r_starved_run;
    logic [31:0]            r_newest_at_starve;
    logic [13:0]            r_widened;
    logic                   r_ever_blended;
    logic [31:0]            r_starve_cnt;
    logic [31:0]            r_snap_cnt;

    // Per-item working registers.
    logic [31:0]             r_tick;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic [CNTW-1:0]         r_pos;
    logic [CNTW-1:0]         r_idx;
    logic [31:0]             r_new_tick;
    logic [PAYLOAD_BITS-1:0] r_new_pl;
    logic [31:0]             r_old_tick;
    logic [PAYLOAD_BITS-1:0] r_old_pl;
    logic [31:0]             r_up_tick;
    logic [PAYLOAD_BITS-1:0] r_up_pl;
    logic signed [CURW-1:0]  r_target;
    logic signed [CURW:0]    r_err;
    logic                    r_starved;
    logic [1:0]              r_mode;
    logic [PAYLOAD_BITS-1:0] r_p1;
    logic [PAYLOAD_BITS-1:0] r_p2;
    logic [BB-1:0]           r_frac;
    logic [TQW-1:0]          r_rem;
    logic [TQW-1:0]          r_span;
    logic [3:0]              r_dcnt;

    // Output register.
    logic                    r_out_valid;
    logic [1:0]              r_o_mode;
    logic [PAYLOAD_BITS-1:0] r_o_p1;
    logic [PAYLOAD_BITS-1:0] r_o_p2;
    logic [BB-1:0]           r_o_frac;
    logic [31:0]             r_o_starve;
    logic [31:0]             r_o_snap;

    // RAM port.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;
    logic [31:0]             rd_tick;
    logic [PAYLOAD_BITS-1:0] rd_pl;

    apjb_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_tick = ram_rdata[RW-1:PAYLOAD_BITS];
    assign rd_pl   = ram_rdata[PAYLOAD_BITS-1:0];

    // Writes happen only while shifting entries up or placing the new one.
    always_comb begin
        ram_we    = (r_state == S_SHIFT_WR) || (r_state == S_INSERT);
        ram_waddr = slot_of(r_oldest, (r_state == S_INSERT) ? r_pos : r_idx);
        ram_wdata = (r_state == S_INSERT) ? {r_tick, r_payload} : ram_rdata;
        case (r_state)
            S_SCAN_RD:  ram_raddr = slot_of(r_oldest, r_pos);
            S_SHIFT_RD: ram_raddr = slot_of(r_oldest, r_idx - CNTW'(1));
            S_NEW_RD:   ram_raddr = slot_of(r_oldest, r_fill - CNTW'(1));
            S_UP_RD:    ram_raddr = slot_of(r_oldest, r_idx - CNTW'(1));
            S_DROP_RD:  ram_raddr = slot_of(r_oldest, CNTW'(1));
            default:    ram_raddr = slot_of(r_oldest, CNTW'(0));
        endcase
    end

    // Restart and late-drop decisions for an incoming push.
    logic signed [CURW-1:0] in_tq;
    logic                   restart_hit;
    logic                   late_hit;

    always_comb begin
        in_tq       = q_of(i_sample_tick);
        restart_hit = r_started &&
            ((in_tq + $signed({{(CURW-16){1'b0}}, r_snap_distance})) < r_cursor);
        late_hit    = r_started && !restart_hit && (in_tq < (r_cursor - $signed(ONE_C)));
    end

    // Cursor step: snap on a large error, otherwise one tick plus a clamped
    // catch-up term.
    logic signed [CURW-1:0] target_now;
    logic signed [CURW:0]   err_now;
    logic [CURW:0]          err_mag;
    logic                   snap_hit;
    logic [23:0]            gain_prod;
    logic [7:0]             corr;
    logic signed [CURW-1:0] cursor_step;

    always_comb begin
        target_now  = q_of(r_new_tick) - $signed({{(CURW-14){1'b0}}, r_delay});
        err_now     = {target_now[CURW-1], target_now} - {r_cursor[CURW-1], r_cursor};
        err_mag     = r_err[CURW] ? (~r_err + 1'b1) : r_err;
        snap_hit    = err_mag > (CURW+1)'(r_snap_distance);
        gain_prod   = err_mag[15:0] * r_catchup_gain;
        corr        = (gain_prod[23:8] > {8'd0, r_max_warp}) ? r_max_warp : gain_prod[15:8];
        cursor_step = r_err[CURW] ? $signed(ONE_C - CURW'(corr)) : $signed(ONE_C + CURW'(corr));
    end

    // One division step of the blend fraction.
    logic [TQW:0] div_twice;
    logic         div_fit;

    always_comb begin
        div_twice = {r_rem, 1'b0};
        div_fit   = div_twice >= {1'b0, r_span};
    end

    // Delay adaptation at the end of an advance.
    logic [13:0] n_delay;
    logic [13:0] n_widened;
    logic [15:0] n_clean_run;
    logic [15:0] n_starved_run;
    logic [31:0] n_newest_at_starve;

    always_comb begin : stat_calc
        logic [DLW-1:0]     d;
        logic [DLW-1:0]     mn;
        logic [DLW-1:0]     mx;
        logic [DLW-1:0]     wd;
        logic [DLW-1:0]     up;
        logic [15:0]        cr;
        logic [15:0]        sr;
        logic signed [34:0] produced;
        d  = DLW'(r_delay);
        mn = DLW'(r_min_delay);
        mx = DLW'(r_max_delay);
        wd = DLW'(r_widened);
        up = d;
        cr = r_clean_run;
        sr = r_starved_run;
        n_newest_at_starve = r_newest_at_starve;
        produced = ($signed({3'b000, r_new_tick}) - $signed({3'b000, r_newest_at_starve})) <<< 1;
        if (r_starved) begin
            if (sr == 16'd0) begin
                n_newest_at_starve = r_new_tick;
                wd = '0;
            end
            if (sr != apjb_pkg::RUN_MAX) begin
                sr = sr + 16'd1;
            end
            cr = '0;
            if (r_ever_blended && (sr <= 16'(r_stall_limit))) begin
                up = d + ONE_D;
                if (up > mx) begin
                    up = mx;
                end
                if (up > d) begin
                    wd = wd + (up - d);
                end
                d = up;
            end
        end else begin
            // A starved run ends: refund the widening if the sender stalled.
            if (sr != 16'd0) begin
                if (produced < $signed({19'd0, sr})) begin
                    d = (d < wd + mn) ? mn : d - wd;
                end
                wd = '0;
            end
            sr = '0;
            if (cr != apjb_pkg::RUN_MAX) begin
                cr = cr + 16'd1;
            end
            if ((cr >= r_shrink_window) && (d > mn)) begin
                d  = (d < mn + HALF_D) ? mn : d - HALF_D;
                cr = '0;
            end
        end
        n_delay       = d[13:0];
        n_widened     = wd[13:0];
        n_clean_run   = cr;
        n_starved_run = sr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_IDLE;
            r_snap_distance    <= apjb_pkg::RST_SNAP_DISTANCE;
            r_min_delay        <= apjb_pkg::RST_MIN_DELAY;
            r_max_delay        <= apjb_pkg::RST_MAX_DELAY;
            r_stall_limit      <= apjb_pkg::RST_STALL_LIMIT;
            r_shrink_window    <= apjb_pkg::RST_SHRINK_WINDOW;
            r_catchup_gain     <= apjb_pkg::RST_CATCHUP_GAIN;
            r_max_warp         <= apjb_pkg::RST_MAX_WARP;
            r_fill             <= '0;
            r_oldest           <= '0;
            r_cursor           <= '0;
            r_started          <= 1'b0;
            r_delay            <= apjb_pkg::RST_INITIAL_DELAY;
            r_clean_run        <= '0;
            r_starved_run      <= '0;
            r_newest_at_starve <= '0;
            r_widened          <= '0;
            r_ever_blended     <= 1'b0;
            r_starve_cnt       <= '0;
            r_snap_cnt         <= '0;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    apjb_pkg::REG_SNAP_DISTANCE: r_snap_distance <= i_cfg_data;
                    apjb_pkg::REG_MIN_DELAY:     r_min_delay     <= i_cfg_data[13:0];
                    apjb_pkg::REG_MAX_DELAY:     r_max_delay     <= i_cfg_data[13:0];
                    // The initial delay only matters at reset, where it
                    // always holds its default.
                    apjb_pkg::REG_INITIAL_DELAY: ;
                    apjb_pkg::REG_STALL_LIMIT:   r_stall_limit   <= i_cfg_data[9:0];
                    apjb_pkg::REG_SHRINK_WINDOW: r_shrink_window <= i_cfg_data;
                    apjb_pkg::REG_CATCHUP_GAIN:  r_catchup_gain  <= i_cfg_data[7:0];
                    apjb_pkg::REG_MAX_WARP:      r_max_warp      <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // In S_DONE an accepted result is replaced by the new one there.
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_kind == apjb_pkg::KIND_PUSH) begin
                            r_tick    <= i_sample_tick;
                            r_payload <= i_sample_payload;
                            r_pos     <= '0;
                            if (restart_hit) begin
                                r_fill             <= '0;
                                r_oldest           <= '0;
                                r_cursor           <= '0;
                                r_started          <= 1'b0;
                                r_clean_run        <= '0;
                                r_starved_run      <= '0;
                                r_newest_at_starve <= '0;
                                r_widened          <= '0;
                                r_ever_blended     <= 1'b0;
                            end
                            r_state <= late_hit ? S_IDLE : S_SCAN_RD;
                        end else if (r_fill == '0) begin
                            r_mode  <= apjb_pkg::MODE_EMPTY;
                            r_p1    <= '0;
                            r_p2    <= '0;
                            r_frac  <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_NEW_RD;
                        end
                    end
                end
                S_SCAN_RD: begin
                    r_state <= (r_pos == r_fill) ? S_PLACE : S_SCAN_CMP;
                end
                S_SCAN_CMP: begin
                    if (rd_tick < r_tick) begin
                        r_pos   <= r_pos + CNTW'(1);
                        r_state <= S_SCAN_RD;
                    end else if (rd_tick == r_tick) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    if (r_fill == DEPTH_C) begin
                        // Full ring: evict the oldest, unless the new sample
                        // would itself be the oldest.
                        if (r_pos == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_oldest <= slot_of(r_oldest, CNTW'(1));
                            r_fill   <= r_fill - CNTW'(1);
                            r_pos    <= r_pos - CNTW'(1);
                            r_idx    <= r_fill - CNTW'(1);
                            r_state  <= S_SHIFT_RD;
                        end
                    end else begin
                        r_idx   <= r_fill;
                        r_state <= S_SHIFT_RD;
                    end
                end
                S_SHIFT_RD: begin
                    r_state <= (r_idx == r_pos) ? S_INSERT : S_SHIFT_WR;
                end
                S_SHIFT_WR: begin
                    r_idx   <= r_idx - CNTW'(1);
                    r_state <= S_SHIFT_RD;
                end
                S_INSERT: begin
                    r_fill  <= r_fill + CNTW'(1);
                    r_state <= S_IDLE;
                end
                S_NEW_RD: begin
                    r_state <= S_OLD_RD;
                end
                S_OLD_RD: begin
                    r_new_tick <= rd_tick;
                    r_new_pl   <= rd_pl;
                    r_state    <= S_ERR;
                end
                S_ERR: begin
                    r_old_tick <= rd_tick;
                    r_old_pl   <= rd_pl;
                    r_target   <= target_now;
                    r_err      <= err_now;
                    r_state    <= S_CUR;
                end
                S_CUR: begin
                    if (!r_started) begin
                        r_cursor  <= r_target;
                        r_started <= 1'b1;
                    end else if (snap_hit) begin
                        r_cursor   <= r_target;
                        r_snap_cnt <= r_snap_cnt + 32'd1;
                    end else begin
                        r_cursor <= r_cursor + cursor_step;
                    end
                    r_state <= S_CLASS;
                end
                S_CLASS: begin
                    r_frac <= '0;
                    if (r_cursor <= q_of(r_old_tick)) begin
                        r_mode    <= apjb_pkg::MODE_HOLD_OLDEST;
                        r_p1      <= r_old_pl;
                        r_p2      <= r_old_pl;
                        r_starved <= 1'b0;
                        r_state   <= S_STAT;
                    end else if (r_cursor >= q_of(r_new_tick)) begin
                        r_mode    <= apjb_pkg::MODE_HOLD_NEWEST;
                        r_p1      <= r_new_pl;
                        r_p2      <= r_new_pl;
                        r_starved <= 1'b1;
                        r_state   <= S_STAT;
                    end else begin
                        r_mode         <= apjb_pkg::MODE_INTERP;
                        r_starved      <= 1'b0;
                        r_ever_blended <= 1'b1;
                        r_idx          <= r_fill - CNTW'(1);
                        r_up_tick      <= r_new_tick;
                        r_up_pl        <= r_new_pl;
                        r_state        <= S_UP_RD;
                    end
                end
                S_UP_RD: begin
                    r_state <= S_UP_CMP;
                end
                S_UP_CMP: begin
                    // Walk down until an entry at or below the cursor: that
                    // one and the entry above it bracket the cursor.
                    if (q_of(rd_tick) > r_cursor) begin
                        r_up_tick <= rd_tick;
                        r_up_pl   <= rd_pl;
                        r_idx     <= r_idx - CNTW'(1);
                        r_state   <= S_UP_RD;
                    end else begin
                        r_p1    <= rd_pl;
                        r_p2    <= r_up_pl;
                        r_rem   <= TQW'(r_cursor - q_of(rd_tick));
                        r_span  <= {r_up_tick - rd_tick, {FRAC_BITS{1'b0}}};
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= div_fit ? TQW'(div_twice - {1'b0, r_span}) : div_twice[TQW-1:0];
                    r_frac <= {r_frac[BB-2:0], div_fit};
                    r_dcnt <= r_dcnt + 4'd1;
                    if (r_dcnt == 4'(BB - 1)) begin
                        r_state <= S_DROP_RD;
                    end
                end
                S_DROP_RD: begin
                    r_state <= (r_fill > CNTW'(2)) ? S_DROP_CMP : S_STAT;
                end
                S_DROP_CMP: begin
                    // Entries that playback has moved past are released.
                    if (q_of(rd_tick) < r_cursor) begin
                        r_oldest <= slot_of(r_oldest, CNTW'(1));
                        r_fill   <= r_fill - CNTW'(1);
                        r_state  <= S_DROP_RD;
                    end else begin
                        r_state <= S_STAT;
                    end
                end
                S_STAT: begin
                    r_delay            <= n_delay;
                    r_widened          <= n_widened;
                    r_clean_run        <= n_clean_run;
                    r_starved_run      <= n_starved_run;
                    r_newest_at_starve <= n_newest_at_starve;
                    if (r_starved) begin
                        r_starve_cnt <= r_starve_cnt + 32'd1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_mode    <= r_mode;
                        r_o_p1      <= r_p1;
                        r_o_p2      <= r_p2;
                        r_o_frac    <= r_frac;
                        r_o_starve  <= r_starve_cnt;
                        r_o_snap    <= r_snap_cnt;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_playout_mode     = r_o_mode;
    assign o_first_payload    = r_o_p1;
    assign o_second_payload   = r_o_p2;
    assign o_blend_fraction   = r_o_frac;
    assign o_starvation_total = r_o_starve;
    assign o_snap_total       = r_o_snap;

    // The fill count never passes the ring size.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_C)
        else $error("fill count beyond ring size");

    // The RAM is written only while a push is being placed.
    a_write_only_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_SHIFT_WR || r_state == S_INSERT))
        else $error("RAM written outside push placement");

    // Bracketing entries are distinct ticks, so the divisor is never zero.
    a_span_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_span != '0))
        else $error("zero span in blend division");

    // A finished advance reaches the output register on the next edge when
    // the receiver does not hold a previous result.
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || i_out_ready)) |=>
            (r_out_valid && r_state == S_IDLE))
        else $error("finished advance not presented");

    // Interpolation is only entered with at least two entries.
    a_interp_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_RD) |-> (r_fill >= CNTW'(2) && r_idx != '0))
        else $error("bracket search with too few entries");

endmodule

`default_nettype wire

// ----- rtl/apjb_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module apjb_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
